>>> hw/rtl/dnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnr_pkg;

    localparam int unsigned HDR_LEN = 54;
    localparam int unsigned POS_W   = 6;

    // Header offsets
    localparam logic [POS_W-1:0] IP_FIRST   = 6'd14;
    localparam logic [POS_W-1:0] IP_LAST    = 6'd33;
    localparam logic [POS_W-1:0] IP_CK_HI   = 6'd24;
    localparam logic [POS_W-1:0] IP_CK_LO   = 6'd25;
    localparam logic [POS_W-1:0] UDP_CK_HI  = 6'd40;
    localparam logic [POS_W-1:0] UDP_CK_LO  = 6'd41;
    localparam logic [POS_W-1:0] DNS_FLAG0  = 6'd44;
    localparam logic [POS_W-1:0] DNS_FLAG1  = 6'd45;
    localparam logic [POS_W-1:0] DNS_AN_HI  = 6'd48;
    localparam logic [POS_W-1:0] DNS_AN_LO  = 6'd49;
    localparam logic [POS_W-1:0] DNS_NS_HI  = 6'd50;
    localparam logic [POS_W-1:0] DNS_NS_LO  = 6'd51;
    localparam logic [POS_W-1:0] DNS_AR_HI  = 6'd52;
    localparam logic [POS_W-1:0] DNS_AR_LO  = 6'd53;
    localparam logic [POS_W-1:0] HDR_LAST   = 6'd53;

    // Rewrite constants
    localparam logic [7:0] DNS_QR_BIT   = 8'b1000_0000;
    localparam logic [7:0] DNS_NXDOMAIN = 8'b0000_0011;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'b0000_0001;

    // Checksum unit request: one header byte and its position
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } csum_req_t;

    // Source position of an output header byte (MAC, IP address and port swaps)
    function automatic logic [POS_W-1:0] hdr_src(input logic [POS_W-1:0] idx);
        logic [POS_W-1:0] src;
        src = idx;
        if (idx <= 6'd5) begin
            src = idx + 6'd6;
        end else if (idx <= 6'd11) begin
            src = idx - 6'd6;
        end else if (idx >= 6'd26 && idx <= 6'd29) begin
            src = idx + 6'd4;
        end else if (idx >= 6'd30 && idx <= 6'd33) begin
            src = idx - 6'd4;
        end else if (idx == 6'd34 || idx == 6'd35) begin
            src = idx + 6'd2;
        end else if (idx == 6'd36 || idx == 6'd37) begin
            src = idx - 6'd2;
        end
        return src;
    endfunction

    // Patch fixed fields of the reply header
    function automatic logic [7:0] hdr_patch(input logic [POS_W-1:0] idx,
                                             input logic [7:0]       data,
                                             input logic [15:0]      ck);
        logic [7:0] res;
        res = data;
        if (idx == IP_CK_HI) begin
            res = ck[15:8];
        end else if (idx == IP_CK_LO) begin
            res = ck[7:0];
        end else if (idx == DNS_FLAG0) begin
            res = data | DNS_QR_BIT;
        end else if (idx == DNS_FLAG1) begin
            res = DNS_NXDOMAIN;
        end else if (idx == DNS_NS_LO) begin
            res = BYTE_ONE;
        end else if (idx == UDP_CK_HI || idx == UDP_CK_LO ||
                     idx == DNS_AN_HI || idx == DNS_AN_LO ||
                     idx == DNS_NS_HI || idx == DNS_AR_HI || idx == DNS_AR_LO) begin
            res = BYTE_ZERO;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dnr_csum.sv
`timescale 1ns / 1ps
`default_nettype none

module dnr_csum (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dnr_pkg::csum_req_t req,
    output logic [15:0]            ck
);
    import dnr_pkg::*;

    logic [15:0] acc_reg, acc_next;
    logic [7:0]  hi_reg;
    logic [7:0]  byte_in;
    logic [16:0] sum;
    logic        in_ip;

    // Treat the checksum field as zero while summing
    assign in_ip   = (req.pos >= IP_FIRST) && (req.pos <= IP_LAST);
    assign byte_in = (req.pos == IP_CK_HI || req.pos == IP_CK_LO) ? BYTE_ZERO : req.data;
    assign sum     = {1'b0, acc_reg} + {1'b0, hi_reg, byte_in};

    // End-around carry add, one word per odd IPv4 header byte; position 0 clears the sum
    always_comb begin
        acc_next = acc_reg;
        if (req.en) begin
            if (req.pos == '0) begin
                acc_next = '0;
            end else if (in_ip && req.pos[0]) begin
                acc_next = sum[15:0] + {15'd0, sum[16]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
        if (req.en && in_ip && !req.pos[0]) begin
            hi_reg <= byte_in;
        end
    end

    assign ck = (acc_reg == 16'hFFFF) ? 16'hFFFF : ~acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dns_nxdomain_reply_rewriter.sv
`timescale 1ns / 1ps
`default_nettype none

// DNS NXDOMAIN reply rewriter.
// Input channel (s_): one query frame byte per item, s_frame_end on the last.
// Output channel (m_): one reply byte per item, m_reply_end on the last,
// m_short_frame set on every byte of a frame shorter than the 54-byte header.
// The first 54 bytes are stored in a header memory while the IPv4 header
// checksum is summed one word per byte pair. Input is taken at one byte per
// cycle during this phase and no output is produced.
// After the 54th byte (or an early frame end) the input stalls and the header
// is replayed from memory: the first byte passes the S_FETCH state, the memory
// read register and the output register, then one byte per cycle follows while
// the receiver keeps m_ready high. The memory read port sets this pace.
// Bytes after the header pass through the output register at one per cycle.
// A stalled receiver holds the output register; the block then stops taking
// input until the register frees up.
// Reset clears the sequencer and the output valid; the block then waits for
// the first byte of a new frame.
module dns_nxdomain_reply_rewriter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_frame_byte,
    input  wire logic       s_frame_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_reply_byte,
    output logic            m_reply_end,
    output logic            m_short_frame
);
    import dnr_pkg::*;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_FETCH,
        S_SEND,
        S_PAYLOAD
    } state_t;

    state_t           state_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] emit_idx_reg;
    logic [POS_W-1:0] last_idx_reg;
    logic             short_reg;
    logic             done_reg;
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic             m_end_reg;
    logic             m_short_reg;

    logic [7:0]       mem [HDR_LEN];
    logic [7:0]       mem_q_reg;

    logic             out_free;
    logic             s_fire;
    logic             send_load;
    logic             emit_last;
    logic [POS_W-1:0] sel_idx;
    logic [POS_W-1:0] rd_addr;
    logic [15:0]      ck;
    csum_req_t        csum_req;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_COLLECT) ||
                       ((state_reg == S_PAYLOAD) && out_free);
    assign s_fire    = s_valid && s_ready;
    assign emit_last = (emit_idx_reg == last_idx_reg);
    assign send_load = (state_reg == S_SEND) && out_free;

    // Read ahead: fetch the next byte while the current one is loaded
    assign sel_idx = (send_load && !emit_last) ? emit_idx_reg + 6'd1 : emit_idx_reg;
    assign rd_addr = short_reg ? sel_idx : hdr_src(sel_idx);

    // Header checksum unit
    assign csum_req.en   = s_fire && (state_reg == S_COLLECT);
    assign csum_req.pos  = pos_reg;
    assign csum_req.data = s_frame_byte;

    dnr_csum u_csum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (csum_req),
        .ck      (ck)
    );

    // Header memory
    always_ff @(posedge aclk) begin
        if (csum_req.en) begin
            mem[pos_reg] <= s_frame_byte;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_COLLECT;
            pos_reg      <= '0;
            emit_idx_reg <= '0;
            last_idx_reg <= '0;
            short_reg    <= 1'b0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_COLLECT: begin
                    if (s_fire) begin
                        if (pos_reg == HDR_LAST) begin
                            last_idx_reg <= HDR_LAST;
                            short_reg    <= 1'b0;
                            done_reg     <= s_frame_end;
                            emit_idx_reg <= '0;
                            pos_reg      <= '0;
                            state_reg    <= S_FETCH;
                        end else if (s_frame_end) begin
                            last_idx_reg <= pos_reg;
                            short_reg    <= 1'b1;
                            done_reg     <= 1'b1;
                            emit_idx_reg <= '0;
                            pos_reg      <= '0;
                            state_reg    <= S_FETCH;
                        end else begin
                            pos_reg <= pos_reg + 6'd1;
                        end
                    end
                end
                S_FETCH: begin
                    state_reg <= S_SEND;
                end
                S_SEND: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_byte_reg    <= short_reg ? mem_q_reg
                                                   : hdr_patch(emit_idx_reg, mem_q_reg, ck);
                        m_end_reg     <= emit_last && done_reg;
                        m_short_reg   <= short_reg;
                        if (emit_last) begin
                            state_reg <= done_reg ? S_COLLECT : S_PAYLOAD;
                        end else begin
                            emit_idx_reg <= emit_idx_reg + 6'd1;
                        end
                    end
                end
                S_PAYLOAD: begin
                    if (s_fire) begin
                        m_valid_reg <= 1'b1;
                        m_byte_reg  <= s_frame_byte;
                        m_end_reg   <= s_frame_end;
                        m_short_reg <= 1'b0;
                        if (s_frame_end) begin
                            state_reg <= S_COLLECT;
                        end
                    end
                end
                default: begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_byte  = m_byte_reg;
    assign m_reply_end   = m_end_reg;
    assign m_short_frame = m_short_reg;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= HDR_LAST)
        else $error("header position out of range");

    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEND) |-> (emit_idx_reg <= last_idx_reg))
        else $error("emit index passed last header byte");

    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SEND) && short_reg) |-> (last_idx_reg < HDR_LAST) && done_reg)
        else $error("short frame with full header length");

    a_no_input_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FETCH) || (state_reg == S_SEND)) |-> !s_ready)
        else $error("input taken during header replay");

    a_fetch_to_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |=> (state_reg == S_SEND) && (emit_idx_reg == '0))
        else $error("replay did not start at first header byte");
`endif

endmodule

`default_nettype wire

>>> sim/dns_nxdomain_reply_rewriter_tb.sv
`timescale 1ns / 1ps

module dns_nxdomain_reply_rewriter_tb;

    import dnr_pkg::*;

    localparam int HDR_N       = 54;
    localparam int DRAIN_QUIET = 16;
    localparam int TAIL_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 460;

    typedef enum int {FILL_RAND, FILL_ONES, FILL_ZEROS} fill_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pause;
    } query_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       shrt;
    } reply_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_frame_byte = 8'h00;
    logic       s_frame_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_reply_byte;
    logic       m_reply_end;
    logic       m_short_frame;

    logic       calm = 1'b0;

    query_t query_q[$];
    reply_t reply_q[$];

    // Predictor state
    logic [7:0] hdr_buf [HDR_N];
    int         hdr_fill = 0;
    bit         in_body = 1'b0;

    int n_in = 0;
    int n_out = 0;
    int n_short = 0;
    int n_hdr_only = 0;
    int n_body = 0;
    int errors = 0;
    int quiet_cycles = 0;
    int hold_cnt = 0;

    dns_nxdomain_reply_rewriter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reply_byte  (m_reply_byte),
        .m_reply_end   (m_reply_end),
        .m_short_frame (m_short_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queue one query frame of the given length
    task automatic add_frame(input int len, input fill_e fill, input bit pause);
        query_t q;
        int i;
        for (i = 0; i < len; i++) begin
            case (fill)
                FILL_ONES:  q.data = 8'hFF;
                FILL_ZEROS: q.data = 8'h00;
                default:    q.data = 8'($urandom_range(0, 255));
            endcase
            q.last  = (i == len - 1);
            q.pause = pause && (i == 0);
            query_q.push_back(q);
        end
    endtask

    // Build the NXDOMAIN reply header from the buffered query header
    task automatic emit_reply_header(input logic last);
        logic [7:0]  rw [HDR_N];
        logic [31:0] sum;
        logic [15:0] ck;
        int i;
        rw = hdr_buf;
        // swap MACs, IPv4 addresses and UDP ports
        for (i = 0; i < 6; i++) begin
            rw[i]     = hdr_buf[i + 6];
            rw[i + 6] = hdr_buf[i];
        end
        for (i = 0; i < 4; i++) begin
            rw[26 + i] = hdr_buf[30 + i];
            rw[30 + i] = hdr_buf[26 + i];
        end
        for (i = 0; i < 2; i++) begin
            rw[34 + i] = hdr_buf[36 + i];
            rw[36 + i] = hdr_buf[34 + i];
        end
        // UDP checksum, DNS flags and counts
        rw[40] = 8'h00;
        rw[41] = 8'h00;
        rw[44] = hdr_buf[44] | DNS_QR_BIT;
        rw[45] = DNS_NXDOMAIN;
        rw[48] = 8'h00;
        rw[49] = 8'h00;
        rw[50] = 8'h00;
        rw[51] = 8'h01;
        rw[52] = 8'h00;
        rw[53] = 8'h00;
        // IPv4 header checksum over bytes 14..33 with the field itself zeroed
        rw[24] = 8'h00;
        rw[25] = 8'h00;
        sum = 32'd0;
        for (i = 0; i < 10; i++) begin
            sum = sum + {16'd0, rw[14 + 2 * i], rw[15 + 2 * i]};
        end
        sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
        ck = (sum[15:0] == 16'hFFFF) ? 16'hFFFF : ~sum[15:0];
        rw[24] = ck[15:8];
        rw[25] = ck[7:0];
        for (i = 0; i < HDR_N; i++) begin
            reply_q.push_back('{rw[i], last && (i == HDR_N - 1), 1'b0});
        end
    endtask

    // Work out the reply bytes that one query byte causes
    task automatic predict_reply(input logic [7:0] b, input logic last);
        int i;
        if (in_body) begin
            reply_q.push_back('{b, last, 1'b0});
            if (last) begin
                in_body = 1'b0;
            end
        end else begin
            hdr_buf[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill < HDR_N && last) begin
                for (i = 0; i < hdr_fill; i++) begin
                    reply_q.push_back('{hdr_buf[i], i == hdr_fill - 1, 1'b1});
                end
                hdr_fill = 0;
                n_short++;
            end else if (hdr_fill == HDR_N) begin
                emit_reply_header(last);
                hdr_fill = 0;
                in_body = !last;
                if (last) begin
                    n_hdr_only++;
                end else begin
                    n_body++;
                end
            end
        end
    endtask

    // Driver: present queued query bytes, idle at random, hold on a pause mark
    always @(posedge aclk) begin
        query_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_reply(s_frame_byte, s_frame_end);
                n_in++;
            end
            calm <= (n_in >= 150 && n_in < 300);
            if (!s_valid || s_ready) begin
                if (query_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (query_q[0].pause &&
                             (reply_q.size() != 0 || hold_cnt < DRAIN_QUIET)) begin
                    s_valid <= 1'b0;
                    hold_cnt = (reply_q.size() != 0) ? 0 : hold_cnt + 1;
                end else if (!calm && $urandom_range(0, 99) < 10) begin
                    s_valid <= 1'b0;
                end else begin
                    nxt = query_q.pop_front();
                    hold_cnt = 0;
                    s_valid      <= 1'b1;
                    s_frame_byte <= nxt.data;
                    s_frame_end  <= nxt.last;
                end
            end
        end
    end

    // Monitor: compare each accepted reply item with the oldest expected one
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_out++;
                if (reply_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected reply item byte=%h end=%b short=%b",
                             $time, m_reply_byte, m_reply_end, m_short_frame);
                end else begin
                    want = reply_q.pop_front();
                    if (m_reply_byte !== want.data) begin
                        errors++;
                        $display("%0t: reply_byte expected %h actual %h",
                                 $time, want.data, m_reply_byte);
                    end
                    if (m_reply_end !== want.last) begin
                        errors++;
                        $display("%0t: reply_end expected %b actual %b",
                                 $time, want.last, m_reply_end);
                    end
                    if (m_short_frame !== want.shrt) begin
                        errors++;
                        $display("%0t: short_frame expected %b actual %b",
                                 $time, want.shrt, m_short_frame);
                    end
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress, %0d reply items still expected",
                     $time, reply_q.size());
            $display("dns_nxdomain_reply_rewriter verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        int frames;
        // Directed: shortest frames, all-ones header (folded sum of all ones),
        // all-zero header with one payload byte
        add_frame(1, FILL_ONES, 1'b0);
        add_frame(2, FILL_ZEROS, 1'b0);
        add_frame(HDR_N, FILL_ONES, 1'b0);
        add_frame(HDR_N + 1, FILL_ZEROS, 1'b0);
        // Random frames, mostly full queries with payload
        frames = 0;
        while (query_q.size() < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                add_frame($urandom_range(1, HDR_N - 1), FILL_RAND, frames == 3);
            end else if (r < 25) begin
                add_frame(HDR_N, FILL_RAND, frames == 3);
            end else begin
                add_frame($urandom_range(HDR_N + 1, HDR_N + 36), FILL_RAND, frames == 3);
            end
            frames++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain stimulus, then wait for every reply item
        while (query_q.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (reply_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d query bytes in %0d frames: %0d short, %0d header only, %0d with payload",
                 n_in, n_short + n_hdr_only + n_body, n_short, n_hdr_only, n_body);
        $display("Checked %0d reply bytes, %0d mismatches", n_out, errors);
        if (errors == 0) begin
            $display("dns_nxdomain_reply_rewriter verification clean");
        end else begin
            $display("dns_nxdomain_reply_rewriter verification failed");
        end
        $finish;
    end

endmodule
